// ===== sv/jacr_pkg.sv =====
// shared types and constants for the joystick axis conditioning block
package jacr_pkg;

  // axis sample arithmetic
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned RANGE_W   = 15;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned MS_W      = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [SAMPLE_W-1:0] AXIS_MAX   = 12'd4095;
  localparam logic [13:0]         AXIS_MID   = 14'd2048;
  // v*2*range/4096 reduces to v*range/2048
  localparam int unsigned         SPAN_SHIFT = 11;

  // register reset values
  localparam logic [SAMPLE_W-1:0] CENTER_RST = 12'd2000;
  localparam logic [RANGE_W-1:0]  RANGE_RST  = 15'd32767;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_INVERT_MASK = 3'd2,
    REG_DEADZONE    = 3'd3,
    REG_OUT_RANGE   = 3'd4,
    REG_MOVE_THRESH = 3'd5,
    REG_TIMEOUT     = 3'd6,
    REG_CB_ENABLE   = 3'd7
  } cfg_idx_t;

  // pipeline load enables handed to each axis
  typedef struct packed {
    logic ld_v;
    logic ld_pos;
  } stage_en_t;

endpackage

// ===== sv/joystick_axis_condition_and_report.sv =====
// top level: joystick axis conditioning with change-triggered position reports
//
// Takes one transfer per clock while in_tready is high: either a millisecond
// tick (in_tuser[0] low) or a pair of 12-bit samples (in_tuser[0] high). Each
// item passes an input register, a conditioning stage (center, deadzone,
// invert, clamp), a mapping stage (one 12x15 multiply per axis) and a
// decision stage that compares with the last reported position and the
// elapsed-millisecond count and loads the output register that drives out_.
// Ticks and samples that cause no report give no output transfer. The pipeline
// holds up to three items while a report waits in the output register; an
// item that causes no report keeps moving even then. Configuration writes take
// effect at once and are meant to be made while the pipeline is empty.
module joystick_axis_condition_and_report (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,   // raw_x[11:0], raw_y[23:12]
  input  logic [1:0]                         in_tuser,   // func[0], want_notify[1]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,  // thumb_x[15:0], thumb_y[31:16]
  output logic                               out_tuser,  // notify[0]
  // configuration writes
  input  logic                               cfg_we,
  input  logic [jacr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jacr_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [jacr_pkg::SAMPLE_W-1:0] center_x_r;
  logic [jacr_pkg::SAMPLE_W-1:0] center_y_r;
  logic [1:0]                    invert_mask_r;
  logic [jacr_pkg::SAMPLE_W-1:0] deadzone_r;
  logic [jacr_pkg::RANGE_W-1:0]  out_range_r;
  logic [jacr_pkg::THR_W-1:0]    move_thresh_r;
  logic [jacr_pkg::MS_W-1:0]     timeout_r;
  logic                          cb_enable_r;

  // pipeline control and side data
  logic                          s1_valid_r, s2_valid_r, s3_valid_r;
  logic                          s1_func_r, s2_func_r, s3_func_r;
  logic                          s1_want_r, s2_want_r, s3_want_r;
  logic [jacr_pkg::SAMPLE_W-1:0] s1_raw_x_r, s1_raw_y_r;
  logic                          s1_free, s2_free, s3_free, s3_go, out_free;
  logic                          in_xfer;
  jacr_pkg::stage_en_t           en;

  // state
  logic signed [jacr_pkg::POS_W-1:0] last_x_r, last_y_r;
  logic        [jacr_pkg::MS_W-1:0]  elapsed_r;
  logic signed [jacr_pkg::POS_W-1:0] pos_x, pos_y;

  // decision
  logic signed [16:0] dx, dy;
  logic        [16:0] adx, ady;
  logic               differs, big, late, fire;

  // output register
  logic                           out_valid_r;
  logic [jacr_pkg::POS_W-1:0]     out_x_r, out_y_r;
  logic                           out_notify_r;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= jacr_pkg::CENTER_RST;
      center_y_r    <= jacr_pkg::CENTER_RST;
      invert_mask_r <= '0;
      deadzone_r    <= '0;
      out_range_r   <= jacr_pkg::RANGE_RST;
      move_thresh_r <= '0;
      timeout_r     <= '0;
      cb_enable_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (jacr_pkg::cfg_idx_t'(cfg_index))
        jacr_pkg::REG_CENTER_X:    center_x_r    <= cfg_wdata[jacr_pkg::SAMPLE_W-1:0];
        jacr_pkg::REG_CENTER_Y:    center_y_r    <= cfg_wdata[jacr_pkg::SAMPLE_W-1:0];
        jacr_pkg::REG_INVERT_MASK: invert_mask_r <= cfg_wdata[1:0];
        jacr_pkg::REG_DEADZONE:    deadzone_r    <= cfg_wdata[jacr_pkg::SAMPLE_W-1:0];
        jacr_pkg::REG_OUT_RANGE:   out_range_r   <= cfg_wdata[jacr_pkg::RANGE_W-1:0];
        jacr_pkg::REG_MOVE_THRESH: move_thresh_r <= cfg_wdata[jacr_pkg::THR_W-1:0];
        jacr_pkg::REG_TIMEOUT:     timeout_r     <= cfg_wdata[jacr_pkg::MS_W-1:0];
        jacr_pkg::REG_CB_ENABLE:   cb_enable_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage advance: an item without a report never waits on the output
  always_comb begin
    out_free = !out_valid_r || out_tready;
    s3_go    = s3_valid_r && (out_free || !fire);
    s3_free  = !s3_valid_r || s3_go;
    s2_free  = !s2_valid_r || s3_free;
    s1_free  = !s1_valid_r || s2_free;
    in_xfer  = in_tvalid && s1_free;
    en.ld_v   = s1_valid_r && s2_free;
    en.ld_pos = s2_valid_r && s3_free;
  end

  assign in_tready = s1_free;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_tvalid;
      if (s2_free) s2_valid_r <= s1_valid_r;
      if (s3_free) s3_valid_r <= s2_valid_r;
    end
  end

  // side data follows the item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r  <= in_tuser[0];
      s1_want_r  <= in_tuser[1];
      s1_raw_x_r <= in_tdata[11:0];
      s1_raw_y_r <= in_tdata[23:12];
    end
    if (en.ld_v) begin
      s2_func_r <= s1_func_r;
      s2_want_r <= s1_want_r;
    end
    if (en.ld_pos) begin
      s3_func_r <= s2_func_r;
      s3_want_r <= s2_want_r;
    end
  end

  // axis datapaths
  jacr_axis u_axis_x (
    .clk      (clk),
    .en       (en),
    .raw      (s1_raw_x_r),
    .center   (center_x_r),
    .inv      (invert_mask_r[0]),
    .deadzone (deadzone_r),
    .range    (out_range_r),
    .pos      (pos_x)
  );

  jacr_axis u_axis_y (
    .clk      (clk),
    .en       (en),
    .raw      (s1_raw_y_r),
    .center   (center_y_r),
    .inv      (invert_mask_r[1]),
    .deadzone (deadzone_r),
    .range    (out_range_r),
    .pos      (pos_y)
  );

  // report decision against the last reported position
  always_comb begin
    dx      = 17'(pos_x) - 17'(last_x_r);
    dy      = 17'(pos_y) - 17'(last_y_r);
    adx     = dx[16] ? 17'(-dx) : 17'(dx);
    ady     = dy[16] ? 17'(-dy) : 17'(dy);
    differs = (pos_x != last_x_r) || (pos_y != last_y_r);
    big     = (adx > {1'b0, move_thresh_r}) || (ady > {1'b0, move_thresh_r})
              || ((pos_x == '0) && (pos_y == '0));
    late    = elapsed_r > timeout_r;
    fire    = s3_func_r && ((differs && big) || late);
  end

  // last position and elapsed count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r  <= '0;
      last_y_r  <= '0;
      elapsed_r <= '0;
    end else if (s3_go) begin
      if (!s3_func_r) begin
        if (elapsed_r != '1) elapsed_r <= elapsed_r + 1'b1;
      end else if (fire) begin
        last_x_r  <= pos_x;
        last_y_r  <= pos_y;
        elapsed_r <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_go && fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go && fire) begin
      out_x_r      <= pos_x;
      out_y_r      <= pos_y;
      out_notify_r <= s3_want_r && cb_enable_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_notify_r;

endmodule

// ===== sv/jacr_axis.sv =====
// one axis: center, deadzone, invert, clamp, then map to the signed output range
module jacr_axis (
  input  logic                                  clk,
  input  jacr_pkg::stage_en_t                   en,
  input  logic [jacr_pkg::SAMPLE_W-1:0]         raw,
  input  logic [jacr_pkg::SAMPLE_W-1:0]         center,
  input  logic                                  inv,
  input  logic [jacr_pkg::SAMPLE_W-1:0]         deadzone,
  input  logic [jacr_pkg::RANGE_W-1:0]          range,
  output logic signed [jacr_pkg::POS_W-1:0]     pos
);

  logic signed [12:0]                   off;
  logic        [12:0]                   mag;
  logic signed [12:0]                   off_dz;
  logic signed [13:0]                   v_wide;
  logic        [jacr_pkg::SAMPLE_W-1:0] v_nxt;
  logic        [jacr_pkg::SAMPLE_W-1:0] v_r;
  logic        [26:0]                   prod;
  logic        [15:0]                   scaled;
  logic signed [16:0]                   pos_wide;
  logic signed [jacr_pkg::POS_W-1:0]    pos_r;

  // offset from center with deadzone
  always_comb begin
    off    = signed'({1'b0, raw}) - signed'({1'b0, center});
    mag    = off[12] ? 13'(-off) : 13'(off);
    off_dz = (mag < {1'b0, deadzone}) ? 13'sd0 : off;
  end

  // place around mid scale and clamp to the sample range
  always_comb begin
    v_wide = inv ? (signed'(jacr_pkg::AXIS_MID) - 14'(off_dz))
                 : (signed'(jacr_pkg::AXIS_MID) + 14'(off_dz));
    if (v_wide >= signed'({2'b00, jacr_pkg::AXIS_MAX})) begin
      v_nxt = jacr_pkg::AXIS_MAX;
    end else if (v_wide <= 14'sd0) begin
      v_nxt = '0;
    end else begin
      v_nxt = v_wide[jacr_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_v) begin
      v_r <= v_nxt;
    end
  end

  // map clamped sample to -range .. range - ceil(range/2048)
  always_comb begin
    prod     = 27'(v_r) * 27'(range);
    scaled   = prod[jacr_pkg::SPAN_SHIFT +: 16];
    pos_wide = signed'({1'b0, scaled}) - signed'({2'b00, range});
  end

  always_ff @(posedge clk) begin
    if (en.ld_pos) begin
      pos_r <= pos_wide[jacr_pkg::POS_W-1:0];
    end
  end

  assign pos = pos_r;

endmodule
